>>> hw/rtl/primitive_and_vertex_renumbering_defines.svh
// Assertion macros for the primitive and vertex renumbering block.
// Used by the port checker; no other dependencies.
`ifndef PRIMITIVE_AND_VERTEX_RENUMBERING_DEFINES_SVH
`define PRIMITIVE_AND_VERTEX_RENUMBERING_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define PVR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pvr port check failed");

// Next-cycle implication, disabled while reset is asserted
`define PVR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pvr port check failed");

// Next-cycle implication that also holds across reset
`define PVR_ASSERT_RST(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("pvr reset check failed");

`endif

>>> hw/rtl/pvr_pkg.sv
// Shared widths, action codes and types for primitive and vertex renumbering.
// No dependencies.
package pvr_pkg;

    localparam int IDX_W   = 16;                 // primitive and vertex index width
    localparam int CNT_W   = 17;                 // counter and triangle_count width
    localparam int EPOCH_W = 8;                  // run tag stored with each map entry
    localparam int DEPTH   = 1 << IDX_W;

    localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [IDX_W-1:0]   IDX_MAX   = {IDX_W{1'b1}};
    localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

    // Action codes
    localparam logic [1:0] ACT_START  = 2'd0;
    localparam logic [1:0] ACT_PRIM   = 2'd1;
    localparam logic [1:0] ACT_VERTEX = 2'd2;

    typedef struct packed {
        logic [1:0]       action;
        logic [IDX_W-1:0] prim;
        logic [IDX_W-1:0] vtx;
    } pvr_item_t;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [IDX_W-1:0]   num;
    } pvr_entry_t;

endpackage

>>> hw/rtl/primitive_and_vertex_renumbering.sv
// Pipeline: an accepted input beat is registered in stage 1, its result in the register
// on m_tdata. Throughput: one beat per cycle unless the output stalls or the input is
// held for a map clear; a vertex does one map read-modify-write per beat, with the last
// write forwarded so back-to-back repeats stay correct. Reset: synchronous, active low;
// afterward a clearing pass over all 65536 vertex map entries runs with s_tready low.
// Every 255th start beat triggers the same pass. Configuration writes are always taken.
module primitive_and_vertex_renumbering
    import pvr_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    // configuration: triangle_count
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    // input channel
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [31:0]      s_tdata,   // [15:0] primitive_index, [31:16] vertex_index
    input  logic [1:0]       s_tuser,   // [1:0] action
    // result channel
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,   // [15:0] new_index
    output logic [1:0]       m_tuser    // [0] is_vertex, [1] first_use
);

    // Vertex map: {epoch, new number} per old vertex index
    pvr_entry_t mem [DEPTH];

    logic [CNT_W-1:0]   tri_count_reg;
    logic [CNT_W-1:0]   tri_cnt_reg, tri_cnt_next;
    logic [CNT_W-1:0]   sph_cnt_reg, sph_cnt_next;
    logic [CNT_W-1:0]   vtx_cnt_reg, vtx_cnt_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic               clearing_reg, clearing_next;
    logic [IDX_W-1:0]   clr_addr_reg;

    pvr_item_t  p1_reg;
    logic       p1_valid_reg;
    pvr_entry_t rd_data_reg;

    logic             fwd_valid_reg;
    logic [IDX_W-1:0] fwd_addr_reg;
    pvr_entry_t       fwd_data_reg;

    logic             m_tvalid_reg;
    logic [IDX_W-1:0] m_index_reg;
    logic             m_is_vertex_reg;
    logic             m_first_reg;

    logic       accept;
    logic       p1_out;
    logic       p1_go;
    logic       out_free;
    logic       wrap_hold;
    pvr_entry_t cur_entry;
    logic       hit;
    logic       vtx_write;
    logic       mem_we;
    logic [IDX_W-1:0] mem_waddr;
    pvr_entry_t mem_wdata;
    logic [CNT_W:0]   sph_sum;
    logic [IDX_W-1:0] res_index;
    logic             res_first;
    logic [IDX_W-1:0] vtx_num;

    // Handshake and stage control
    assign out_free  = !m_tvalid_reg || m_tready;
    assign p1_out    = (p1_reg.action == ACT_PRIM) || (p1_reg.action == ACT_VERTEX);
    assign p1_go     = p1_valid_reg && (!p1_out || out_free);
    // hold input while a start that wraps the epoch is pending: the map must clear first
    assign wrap_hold = p1_valid_reg && (p1_reg.action == ACT_START) && (epoch_reg == EPOCH_MAX);
    assign s_tready  = !clearing_reg && !wrap_hold && (!p1_valid_reg || p1_go);
    assign accept    = s_tvalid && s_tready;

    // Pick the newest copy of the entry: the last write may have missed the read
    assign cur_entry = (fwd_valid_reg && (fwd_addr_reg == p1_reg.vtx)) ? fwd_data_reg
                                                                         : rd_data_reg;
    assign hit       = (cur_entry.epoch == epoch_reg);
    assign vtx_num   = (vtx_cnt_reg > CNT_W'(IDX_MAX)) ? IDX_MAX : vtx_cnt_reg[IDX_W-1:0];
    assign vtx_write = p1_go && (p1_reg.action == ACT_VERTEX) && !hit;
    assign sph_sum   = {1'b0, tri_count_reg} + {1'b0, sph_cnt_reg};

    // Counters, epoch and result of the stage-1 item
    always_comb begin
        tri_cnt_next  = tri_cnt_reg;
        sph_cnt_next  = sph_cnt_reg;
        vtx_cnt_next  = vtx_cnt_reg;
        epoch_next    = epoch_reg;
        clearing_next = clearing_reg;
        res_index     = '0;
        res_first     = 1'b0;
        if (clearing_reg && (clr_addr_reg == IDX_MAX)) begin
            clearing_next = 1'b0;
        end
        if (p1_go) begin
            case (p1_reg.action)
                ACT_START: begin
                    tri_cnt_next = '0;
                    sph_cnt_next = '0;
                    vtx_cnt_next = '0;
                    if (epoch_reg == EPOCH_MAX) begin
                        epoch_next    = EPOCH_FIRST;
                        clearing_next = 1'b1;
                    end else begin
                        epoch_next = epoch_reg + EPOCH_W'(1);
                    end
                end
                ACT_PRIM: begin
                    if ({1'b0, p1_reg.prim} < tri_count_reg) begin
                        res_index = (tri_cnt_reg > CNT_W'(IDX_MAX)) ? IDX_MAX
                                                                     : tri_cnt_reg[IDX_W-1:0];
                        if (tri_cnt_reg != CNT_MAX) tri_cnt_next = tri_cnt_reg + CNT_W'(1);
                    end else begin
                        res_index = (sph_sum > (CNT_W+1)'(IDX_MAX)) ? IDX_MAX
                                                                     : sph_sum[IDX_W-1:0];
                        if (sph_cnt_reg != CNT_MAX) sph_cnt_next = sph_cnt_reg + CNT_W'(1);
                    end
                end
                ACT_VERTEX: begin
                    if (hit) begin
                        res_index = cur_entry.num;
                    end else begin
                        res_index = vtx_num;
                        res_first = 1'b1;
                        if (vtx_cnt_reg != CNT_MAX) vtx_cnt_next = vtx_cnt_reg + CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Memory write port: clearing pass or first-use write
    always_comb begin
        mem_we    = clearing_reg || vtx_write;
        mem_waddr = clearing_reg ? clr_addr_reg : p1_reg.vtx;
        mem_wdata = clearing_reg ? pvr_entry_t'('0) : pvr_entry_t'{epoch: epoch_reg,
                                                                   num: vtx_num};
    end

    // Map memory: one write, one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (accept) rd_data_reg <= mem[s_tdata[31:16]];
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tri_count_reg <= '0;
            tri_cnt_reg   <= '0;
            sph_cnt_reg   <= '0;
            vtx_cnt_reg   <= '0;
            epoch_reg     <= EPOCH_FIRST;
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            p1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_we) tri_count_reg <= cfg_wdata;
            tri_cnt_reg  <= tri_cnt_next;
            sph_cnt_reg  <= sph_cnt_next;
            vtx_cnt_reg  <= vtx_cnt_next;
            epoch_reg    <= epoch_next;
            clearing_reg <= clearing_next;
            // advance the clearing address; it wraps to zero at the end of a pass
            if (clearing_reg) clr_addr_reg <= clr_addr_reg + IDX_W'(1);
            // stage 1 occupancy
            if (accept) begin
                p1_valid_reg <= 1'b1;
            end else if (p1_go) begin
                p1_valid_reg <= 1'b0;
            end
            // drop the forwarded entry while the map is cleared
            if (clearing_reg) begin
                fwd_valid_reg <= 1'b0;
            end else if (vtx_write) begin
                fwd_valid_reg <= 1'b1;
            end
            // output beat
            if (p1_go && p1_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_reg <= pvr_item_t'{action: s_tuser, prim: s_tdata[15:0], vtx: s_tdata[31:16]};
        end
        if (vtx_write) begin
            fwd_addr_reg <= p1_reg.vtx;
            fwd_data_reg <= mem_wdata;
        end
        if (p1_go && p1_out) begin
            m_index_reg     <= res_index;
            m_is_vertex_reg <= (p1_reg.action == ACT_VERTEX);
            m_first_reg     <= res_first;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_index_reg;
    assign m_tuser  = {m_first_reg, m_is_vertex_reg};

endmodule

>>> hw/rtl/pvr_checker.sv
// Port-level checks for primitive_and_vertex_renumbering, attached by bind.
// Depends on primitive_and_vertex_renumbering_defines.svh.
`include "primitive_and_vertex_renumbering_defines.svh"

module pvr_checker (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [15:0]      m_tdata,
    input logic [1:0]       m_tuser
);

    // Hold a stalled result beat
    `PVR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tdata, m_tuser}))

    // A primitive result never flags first use
    `PVR_ASSERT_NOW(a_prim_no_first, m_tvalid && !m_tuser[0], !m_tuser[1])

    // Reset empties the output and starts the map clear with input held off
    `PVR_ASSERT_RST(a_reset_clear, !aresetn, !s_tready && !m_tvalid)

    // Nothing is accepted in the cycle after reset: the clearing pass is running
    `PVR_ASSERT_RST(a_reset_no_accept, !aresetn, !(s_tvalid && s_tready))

endmodule

bind primitive_and_vertex_renumbering pvr_checker u_pvr_checker (.*);

>>> tb/tb_primitive_and_vertex_renumbering.sv
// Self-checking testbench for primitive_and_vertex_renumbering.
// Uses pvr_pkg for widths and action codes. Drives both stream channels with random
// stalls and checks every result beat against a built-in renumbering predictor.
`timescale 1ns / 100ps

module tb_primitive_and_vertex_renumbering;
    import pvr_pkg::*;

    localparam logic [1:0] ACT_UNUSED    = 2'd3;   // action code the block ignores
    localparam int         ITEMS_TARGET  = 400;
    localparam int         QUIET_TAIL    = 340;    // no idling once this many beats are in
    localparam int         SETTLE_CYCLES = 16;     // well past the stage-1 and output registers
    localparam int         REPORT_LIMIT  = 10;

    // One result beat, split into its fields
    typedef struct packed {
        logic [IDX_W-1:0] new_index;
        logic             is_vertex;
        logic             first_use;
    } renumber_t;

    // Predicts new primitive and vertex numbers and holds them until they come out
    class renumber_tracker;
        logic [CNT_W-1:0] tri_total;
        logic [CNT_W-1:0] tri_next;
        logic [CNT_W-1:0] sph_next;
        logic [CNT_W-1:0] vtx_next;
        logic [IDX_W-1:0] vtx_number [int];
        renumber_t        awaited [$];
        int               errors;
        int               checked;

        function new();
            tri_total = '0;
            tri_next  = '0;
            sph_next  = '0;
            vtx_next  = '0;
            errors    = 0;
            checked   = 0;
        endfunction

        // Saturate counters at their top value
        function logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
            return (c == CNT_MAX) ? c : c + 1'b1;
        endfunction

        function logic [IDX_W-1:0] clamp(input logic [CNT_W:0] v);
            return (v > IDX_MAX) ? IDX_MAX : v[IDX_W-1:0];
        endfunction

        function void note_beat(input logic [1:0] act, input logic [IDX_W-1:0] prim,
                                input logic [IDX_W-1:0] vtx);
            logic [CNT_W:0] num;
            logic           fresh;
            case (act)
                ACT_START: begin
                    vtx_number.delete();
                    tri_next = '0;
                    sph_next = '0;
                    vtx_next = '0;
                end
                ACT_PRIM: begin
                    // triangles count from zero, spheres from triangle_count
                    if ({1'b0, prim} < tri_total) begin
                        num      = {1'b0, tri_next};
                        tri_next = bump(tri_next);
                    end else begin
                        num      = {1'b0, tri_total} + {1'b0, sph_next};
                        sph_next = bump(sph_next);
                    end
                    awaited.insert(awaited.size(), renumber_t'{clamp(num), 1'b0, 1'b0});
                end
                ACT_VERTEX: begin
                    // first use takes the next vertex number, later uses reread it
                    fresh = !vtx_number.exists(int'(vtx));
                    if (fresh) begin
                        vtx_number[int'(vtx)] = clamp({1'b0, vtx_next});
                        vtx_next = bump(vtx_next);
                    end
                    awaited.insert(awaited.size(),
                                   renumber_t'{vtx_number[int'(vtx)], 1'b1, fresh});
                end
                default: ;
            endcase
        endfunction

        function void check_beat(input logic [15:0] data, input logic [1:0] user);
            renumber_t got;
            renumber_t want;
            got = renumber_t'{data, user[0], user[1]};
            if (awaited.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: unexpected result index=%0d vtx=%0b first=%0b",
                             $realtime, got.new_index, got.is_vertex, got.first_use);
            end else begin
                want = awaited.pop_front();
                checked++;
                if (got.new_index !== want.new_index || got.is_vertex !== want.is_vertex ||
                    got.first_use !== want.first_use) begin
                    errors++;
                    // fields shown as index/is_vertex/first_use
                    if (errors <= REPORT_LIMIT)
                        $display("%0t: mismatch, expected %0d/%0b/%0b, got %0d/%0b/%0b",
                                 $realtime, want.new_index, want.is_vertex, want.first_use,
                                 got.new_index, got.is_vertex, got.first_use);
                end
            end
        endfunction
    endclass

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_wdata;
    logic             s_tvalid;
    logic             s_tready;
    logic [31:0]      s_tdata;   // [15:0] primitive_index, [31:16] vertex_index
    logic [1:0]       s_tuser;   // [1:0] action
    logic             m_tvalid;
    logic             m_tready;
    logic [15:0]      m_tdata;   // [15:0] new_index
    logic [1:0]       m_tuser;   // [0] is_vertex, [1] first_use

    renumber_tracker tracker = new();
    bit              idle_on = 1'b1;
    int              items_in = 0;
    int              starts_in = 0;
    int              cfg_writes = 0;
    int              hold_left = 0;

    primitive_and_vertex_renumbering dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #1 aclk = ~aclk;

    // Stall the result channel in random bursts while idle_on is set
    always @(posedge aclk) begin
        if (!idle_on) begin
            m_tready <= 1'b1;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            hold_left = $urandom_range(0, 3);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Check each accepted result beat
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_beat(m_tdata, m_tuser);
    end

    // Present one input beat, with an optional gap first, and hold it until accepted
    task automatic send_beat(input logic [1:0] act, input logic [IDX_W-1:0] prim,
                             input logic [IDX_W-1:0] vtx);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {vtx, prim};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.note_beat(act, prim, vtx);
        if (act != ACT_UNUSED) items_in++;
        if (act == ACT_START) starts_in++;
    endtask

    // Drop valid and wait until every pending result is out, then let the pipe drain
    task automatic settle();
        s_tvalid <= 1'b0;
        while (tracker.awaited.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_triangle_count(input logic [CNT_W-1:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        tracker.tri_total = value;
        cfg_we <= 1'b0;
        cfg_writes++;
    endtask

    // Occasionally slip in a beat with random action and fields
    task automatic maybe_noise();
        if ($urandom_range(0, 9) == 0)
            send_beat(2'($urandom_range(0, 3)), IDX_W'($urandom), IDX_W'($urandom));
    endtask

    // An optional start, primitives in traversal order, then three corners per
    // triangle from a small vertex pool so that vertices get reused
    task automatic run_sequence();
        int               n_prims;
        int               n_tris;
        int               pool;
        int               base;
        logic [IDX_W-1:0] prim;
        n_tris  = 0;
        n_prims = $urandom_range(1, 10);
        pool    = $urandom_range(3, 12);
        base    = $urandom_range(0, 65535 - 12);
        if ($urandom_range(0, 5) != 0)
            send_beat(ACT_START, IDX_W'($urandom), IDX_W'($urandom));
        repeat (n_prims) begin
            maybe_noise();
            if (tracker.tri_total != 0 &&
                (tracker.tri_total > IDX_MAX || $urandom_range(0, 1) == 0))
                prim = IDX_W'($urandom_range(0, int'(tracker.tri_total) - 1));
            else
                prim = IDX_W'($urandom_range(int'(tracker.tri_total), 65535));
            if ({1'b0, prim} < tracker.tri_total) n_tris++;
            send_beat(ACT_PRIM, prim, IDX_W'($urandom));
        end
        repeat (3 * n_tris) begin
            maybe_noise();
            send_beat(ACT_VERTEX, IDX_W'($urandom), IDX_W'(base + $urandom_range(0, pool - 1)));
        end
    endtask

    initial begin
        logic [CNT_W-1:0] value;
        int               phase;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= ACT_START;
        m_tready  <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extreme indices, sphere number clamp, repeats, ignored action
        write_triangle_count(17'd65535);
        send_beat(ACT_START, 16'h0000, 16'h0000);
        send_beat(ACT_PRIM, 16'h0000, 16'hFFFF);
        send_beat(ACT_PRIM, 16'hFFFF, 16'h0000);
        send_beat(ACT_PRIM, 16'hFFFF, 16'h0000);
        send_beat(ACT_PRIM, 16'h0001, 16'h0000);
        send_beat(ACT_VERTEX, 16'hFFFF, 16'h0000);
        send_beat(ACT_VERTEX, 16'h0000, 16'hFFFF);
        send_beat(ACT_VERTEX, 16'h0000, 16'hFFFF);
        send_beat(ACT_VERTEX, 16'h0000, 16'h0000);
        send_beat(ACT_VERTEX, 16'h5555, 16'hAAAA);
        send_beat(ACT_VERTEX, 16'hAAAA, 16'h5555);
        send_beat(ACT_UNUSED, 16'hFFFF, 16'hFFFF);
        send_beat(ACT_START, 16'hFFFF, 16'hFFFF);
        send_beat(ACT_VERTEX, 16'h0000, 16'hFFFF);
        send_beat(ACT_PRIM, 16'h5555, 16'h0000);
        // all spheres, then all triangles
        write_triangle_count(17'd0);
        send_beat(ACT_PRIM, 16'h0000, 16'h0000);
        send_beat(ACT_PRIM, 16'hFFFF, 16'h0000);
        write_triangle_count(17'd65536);
        send_beat(ACT_PRIM, 16'hFFFF, 16'h0000);
        send_beat(ACT_START, 16'h0000, 16'h0000);
        send_beat(ACT_PRIM, 16'hAAAA, 16'h5555);

        // Random: rotate triangle_count through extremes and random values
        phase = 0;
        while (items_in < ITEMS_TARGET) begin
            case (phase % 5)
                0:       value = 17'd0;
                1:       value = 17'd65536;
                2:       value = CNT_W'($urandom_range(1, 65535));
                3:       value = CNT_W'($urandom_range(1, 32));
                default: value = CNT_W'(65535 - $urandom_range(0, 3));
            endcase
            write_triangle_count(value);
            idle_on = (items_in < QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 3)) run_sequence();
            phase++;
        end

        settle();
        $display("Sent %0d input beats (%0d starts) across %0d triangle_count settings.",
                 items_in, starts_in, cfg_writes);
        $display("Checked %0d result beats, %0d mismatches.", tracker.checked, tracker.errors);
        if (tracker.errors == 0 && tracker.awaited.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Hard stop well beyond the clearing pass and the slowest stalled run
    initial begin
        #1_200_000;
        $display("Timeout with %0d results still pending.", tracker.awaited.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
